// File: hw/rtl/gidc_pkg.sv
// gidc_pkg: shared types, constants and state codes for the gpio interrupt
// dispatcher with click debounce
// no dependencies
package gidc_pkg;

    // number of pins held; the scan covers at most sixteen of them
    localparam int PIN_COUNT  = 16;
    localparam int SCAN_COUNT = (PIN_COUNT < 16) ? PIN_COUNT : 16;
    localparam int IDX_W      = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;

    localparam logic       OP_CONFIG = 1'b0;
    localparam logic       OP_EVENT  = 1'b1;

    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_HIGH  = 3'd5;
    localparam logic [2:0] MODE_CLICK = 3'd6;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd15;

    typedef struct packed {
        logic        operation;
        logic [3:0]  pin;
        logic [2:0]  mode;
        logic [15:0] status_mask;
        logic [15:0] pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [3:0] event_pin;
        logic       event_level;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_cfg;
        logic load_evt;
        logic step;
        logic flush;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cur_fire;
        logic held_valid;
        logic out_free;
        logic idx_last;
    } dp_status_t;

endpackage

// File: hw/rtl/gidc_ctrl.sv
// gidc_ctrl: sequencer for configure items, pin scan and final flush
// depends on gidc_pkg
module gidc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_operation,
    output logic                 in_ready,
    input  gidc_pkg::dp_status_t status,
    output gidc_pkg::dp_cmd_t    cmd
);
    import gidc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a firing pin cannot retire while the held result has nowhere to go
    assign stall = status.cur_fire && status.held_valid && !status.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_operation == OP_EVENT)
                    begin
                        cmd.load_evt = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_cfg = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    cmd.step = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!status.held_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/gidc_datapath.sv
// gidc_datapath: per-pin trigger state, scan index, held result and output register
// depends on gidc_pkg
module gidc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gidc_pkg::in_item_t   in_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  gidc_pkg::dp_cmd_t    cmd,
    output gidc_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gidc_pkg::out_item_t  out_data
);
    import gidc_pkg::*;

    logic [7:0]            debounce_reg;
    logic [2:0]            kind_reg [SCAN_COUNT];
    logic                  click_reg [SCAN_COUNT];
    logic [7:0]            cnt_reg [SCAN_COUNT];
    logic [IDX_W-1:0]      idx_reg;
    logic [SCAN_COUNT-1:0] status_reg;
    logic [SCAN_COUNT-1:0] levels_reg;
    logic                  held_valid_reg;
    out_item_t             held_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic [2:0]       cur_kind;
    logic             cur_click;
    logic [7:0]       cur_cnt;
    logic             cur_lv;
    logic             cur_settled;
    logic [7:0]       cnt_step;
    logic             cur_fire;
    logic             out_free;
    logic             push_out;
    out_item_t        push_item;
    logic             cfg_hit;
    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_lv;

    assign cur_kind    = kind_reg[idx_reg];
    assign cur_click   = click_reg[idx_reg];
    assign cur_cnt     = cnt_reg[idx_reg];
    assign cur_lv      = levels_reg[idx_reg];
    // settled level is the low bit of (high - kind)
    assign cur_settled = ~cur_kind[0];
    assign cnt_step    = (cur_settled != cur_lv) ? cur_cnt - 8'd1 : cur_cnt + 8'd1;
    assign cur_fire    = status_reg[idx_reg] && (cur_kind != MODE_OFF)
                         && (!cur_click || (cnt_step == 8'd0));

    assign out_free = !out_valid_reg || out_ready;

    assign cfg_hit = cmd.load_cfg && ({1'b0, in_data.pin} < 5'(SCAN_COUNT));
    assign cfg_idx = IDX_W'(in_data.pin);
    assign cfg_lv  = in_data.pin_levels[in_data.pin];

    // held result leaves as not-last when another pin fires, as last on flush
    always_comb
    begin
        push_out  = 1'b0;
        push_item = held_reg;
        if (cmd.step && cur_fire && held_valid_reg)
        begin
            push_out       = 1'b1;
            push_item.last = 1'b0;
        end
        else if (cmd.flush)
        begin
            push_out       = 1'b1;
            push_item.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCAN_COUNT; i++)
            begin
                kind_reg[i]  <= MODE_OFF;
                click_reg[i] <= 1'b0;
                cnt_reg[i]   <= 8'd0;
            end
        end
        else if (cfg_hit)
        begin
            if (in_data.mode == MODE_CLICK)
            begin
                click_reg[cfg_idx] <= 1'b1;
                cnt_reg[cfg_idx]   <= debounce_reg;
                kind_reg[cfg_idx]  <= 3'(MODE_HIGH - {2'b00, cfg_lv});
            end
            else
            begin
                click_reg[cfg_idx] <= 1'b0;
                cnt_reg[cfg_idx]   <= 8'd0;
                kind_reg[cfg_idx]  <= in_data.mode;
            end
        end
        else if (cmd.step && status_reg[idx_reg] && (cur_kind != MODE_OFF) && cur_click)
        begin
            if (cnt_step == 8'd0)
            begin
                cnt_reg[idx_reg]  <= debounce_reg;
                kind_reg[idx_reg] <= 3'(MODE_HIGH - {2'b00, cur_lv});
            end
            else
            begin
                cnt_reg[idx_reg] <= cnt_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_evt)
        begin
            status_reg <= in_data.status_mask[SCAN_COUNT-1:0];
            levels_reg <= in_data.pin_levels[SCAN_COUNT-1:0];
        end
        if (cmd.step && cur_fire)
        begin
            held_reg.event_pin   <= 4'(idx_reg);
            held_reg.event_level <= cur_lv;
            held_reg.last        <= 1'b0;
        end
        if (push_out)
        begin
            out_reg <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_evt)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.step && cur_fire)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end

            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.cur_fire   = cur_fire;
    assign status.held_valid = held_valid_reg;
    assign status.out_free   = out_free;
    assign status.idx_last   = (idx_reg == IDX_W'(SCAN_COUNT - 1));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/gpio_irq_dispatch_click_debounce.sv
// gpio_irq_dispatch_click_debounce: top level of the gpio interrupt dispatcher
// depends on gidc_pkg, gidc_ctrl and gidc_datapath
//
//   channel   direction  handshake               payload
//   in        sink       in_valid / in_ready     in_data (in_item_t)
//   out       source     out_valid / out_ready   out_data (out_item_t)
//   cfg       sink       cfg_wr_en               cfg_wr_data (debounce count)
//
// a configure item returns the block to idle at once
// an event item closes the input until its scan is done: after the transfer,
// the pins go one per cycle unless the output stalls, then comes the flush state
// results leave through a one-deep output register, the last one on flush
// a stalled output holds the scan on a firing pin until the register drains
// reset clears all pin trigger state, counters and the debounce count to 15
module gpio_irq_dispatch_click_debounce (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gidc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gidc_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    import gidc_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: idle accepts transfers, scan walks the pins, flush sends the last result
    gidc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_operation (in_data.operation),
        .in_ready     (in_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath: per-pin trigger kind, click flag and counter, plus the result registers
    gidc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// File: hw/rtl/gidc_checker.sv
// gidc_checker: port-level assertions for the dispatcher, bound to the top level
// depends on gidc_pkg and gpio_irq_dispatch_click_debounce
module gidc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input gidc_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input gidc_pkg::out_item_t out_data
);
    import gidc_pkg::*;

    // a waiting result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an event transfer starts a scan and closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.operation == OP_EVENT) |=> !in_ready)
        else $error("input open during scan");

    // a configure transfer leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.operation == OP_CONFIG) |=> in_ready)
        else $error("configure transfer left block busy");

    // no result while reset is held
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind gpio_irq_dispatch_click_debounce gidc_checker u_gidc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: verif/gpio_irq_dispatch_click_debounce_tb.sv
// gpio_irq_dispatch_click_debounce_tb: self-checking bench for the gpio interrupt dispatcher
// with click debounce; drives configure and event transfers, predicts every reported pin event
// depends on gidc_pkg and gpio_irq_dispatch_click_debounce
module gpio_irq_dispatch_click_debounce_tb;

    import gidc_pkg::*;

    // trigger modes the package leaves unnamed
    localparam logic [2:0] MODE_RISE  = 3'd1;
    localparam logic [2:0] MODE_FALL  = 3'd2;
    localparam logic [2:0] MODE_ANY   = 3'd3;
    localparam logic [2:0] MODE_LOW   = 3'd4;
    localparam logic [2:0] MODE_SEVEN = 3'd7;

    // a directed row either names its results outright or leaves them to the predictor
    localparam int PREDICTED      = -1;
    // one pin per cycle when the output does not stall, plus flush and output register, with margin
    localparam int SCAN_DRAIN     = 24;
    localparam int RAND_PER_PHASE = 8;
    localparam int END_LIMIT      = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        in_item_t  item;
        int        typed_n;
        out_item_t typed_res;
    } row_t;

    // receiver behaviour, re-chosen each time the six-bit tick counter wraps
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_PATTERN,
        READY_COIN,
        READY_SPARSE
    } stall_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    // predictor copy of the per-pin state and the debounce register
    logic [2:0] trig_q  [PIN_COUNT];
    logic       click_q [PIN_COUNT];
    logic [7:0] count_q [PIN_COUNT];
    logic [7:0] debounce_q;

    out_item_t  scan_res[$];        // events raised by the item just accepted
    out_item_t  pending_events[$];  // events still owed by the block
    row_t       dir_rows[$];
    int         mismatch_count = 0;
    int         burst_left = 0;

    stall_kind_t stall_kind = READY_ALWAYS;
    logic [15:0] stall_pat  = 16'hA5C3;
    logic [5:0]  stall_tick = '0;

    gpio_irq_dispatch_click_debounce dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: stretches of full throughput, a rotating pattern, coin flips and long stalls
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == '0)
        begin
            stall_kind <= stall_kind_t'($urandom_range(0, 3));
            stall_pat  <= 16'($urandom);
        end
        else
        begin
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
        end
        case (stall_kind)
            READY_ALWAYS:  out_ready <= 1'b1;
            READY_PATTERN: out_ready <= stall_pat[0];
            READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
            default:       out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endfunction

    // predictor: applies one accepted item to the state copy and fills scan_res
    function automatic void dispatch_model(in_item_t it);
        logic       lv;
        logic [2:0] diff;
        logic       settled;
        logic       fire;
        out_item_t  r;
        int         p;
        scan_res.delete();
        if (it.operation == OP_CONFIG)
        begin
            if (int'(it.pin) < PIN_COUNT)
            begin
                if (it.mode == MODE_CLICK)
                begin
                    // click pin settles at its present level and waits for the other one
                    lv               = it.pin_levels[it.pin];
                    click_q[it.pin]  = 1'b1;
                    count_q[it.pin]  = debounce_q;
                    trig_q[it.pin]   = MODE_HIGH - {2'b00, lv};
                end
                else
                begin
                    click_q[it.pin]  = 1'b0;
                    count_q[it.pin]  = 8'd0;
                    trig_q[it.pin]   = it.mode;
                end
            end
            return;
        end
        for (p = 0; p < SCAN_COUNT; p++)
        begin
            if (trig_q[p] != MODE_OFF && it.status_mask[p])
            begin
                lv   = it.pin_levels[p];
                fire = 1'b1;
                if (click_q[p])
                begin
                    diff    = MODE_HIGH - trig_q[p];
                    settled = diff[0];
                    // counts down towards the awaited level, up while it bounces back, wraps
                    if (settled != lv)
                        count_q[p] = count_q[p] - 8'd1;
                    else
                        count_q[p] = count_q[p] + 8'd1;
                    fire = (count_q[p] == 8'd0);
                    if (fire)
                    begin
                        count_q[p] = debounce_q;
                        trig_q[p]  = MODE_HIGH - {2'b00, lv};
                    end
                end
                if (fire)
                begin
                    r.event_pin   = 4'(p);
                    r.event_level = lv;
                    r.last        = 1'b0;
                    scan_res.push_back(r);
                end
            end
        end
        if (scan_res.size() > 0)
            scan_res[scan_res.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_row(logic op, logic [3:0] pin, logic [2:0] mode,
                                    logic [15:0] mask, logic [15:0] levels, int n,
                                    logic [3:0] epin = 4'd0, logic elvl = 1'b0);
        row_t r;
        r.item.operation   = op;
        r.item.pin         = pin;
        r.item.mode        = mode;
        r.item.status_mask = mask;
        r.item.pin_levels  = levels;
        r.typed_n          = n;
        r.typed_res        = '{event_pin: epin, event_level: elvl, last: 1'b1};
        dir_rows.push_back(r);
    endfunction

    // sender: bursts of back-to-back transfers separated by random gaps;
    // with hold set it first waits for every owed event to drain
    task automatic deliver(in_item_t it, bit hold);
        if (hold)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_events.size() != 0)
                @(posedge clk);
        end
        else if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // register write only once the block has gone quiet
    task automatic set_debounce(logic [7:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        // an event item with no result may still be scanning
        repeat (SCAN_DRAIN) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        debounce_q   = val;
        burst_left   = 0;
    endtask

    // result checker: every output transfer against the oldest owed event
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                note_failure($sformatf("unexpected transfer pin %0d level %0b last %0b",
                                       out_data.event_pin, out_data.event_level,
                                       out_data.last));
            end
            else
            begin
                want = pending_events.pop_front();
                if (out_data.event_pin !== want.event_pin
                    || out_data.event_level !== want.event_level
                    || out_data.last !== want.last)
                    note_failure($sformatf("exp pin %0d level %0b last %0b, got %0d %0b %0b",
                                           want.event_pin, want.event_level, want.last,
                                           out_data.event_pin, out_data.event_level,
                                           out_data.last));
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] phase_debounce[4];
        in_item_t   it;
        int         ph;
        int         k;
        int         wait_cycles;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        for (k = 0; k < PIN_COUNT; k++)
        begin
            trig_q[k]  = MODE_OFF;
            click_q[k] = 1'b0;
            count_q[k] = 8'd0;
        end
        debounce_q = DEBOUNCE_RESET;

        // directed part, run with the debounce count left at its reset value
        // nothing is enabled straight after reset
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'hFFFF, 16'hFFFF, 0);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'h0000, 16'h0000, 0);
        add_row(OP_CONFIG, 4'd0,  MODE_RISE,  16'hFFFF, 16'h0000, 0);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'h0001, 16'h0000, 1, 4'd0, 1'b0);
        // mode seven reports directly like any other nonzero trigger
        add_row(OP_CONFIG, 4'd15, MODE_SEVEN, 16'h0000, 16'hFFFF, 0);
        add_row(OP_EVENT,  4'd15, MODE_SEVEN, 16'h8000, 16'hFFFF, 1, 4'd15, 1'b1);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'hFFFF, 16'h7FFE, PREDICTED);
        add_row(OP_CONFIG, 4'd1,  MODE_FALL,  16'h0000, 16'h0000, 0);
        add_row(OP_CONFIG, 4'd2,  MODE_ANY,   16'h0000, 16'h0000, 0);
        add_row(OP_CONFIG, 4'd3,  MODE_LOW,   16'h0000, 16'h0000, 0);
        add_row(OP_CONFIG, 4'd4,  MODE_HIGH,  16'h0000, 16'h0000, 0);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'h001E, 16'hAAAA, PREDICTED);
        // click pins settling low and high, stepped both ways
        add_row(OP_CONFIG, 4'd5,  MODE_CLICK, 16'h0000, 16'h0000, 0);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'h0020, 16'h0020, PREDICTED);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'h0020, 16'h0000, PREDICTED);
        add_row(OP_CONFIG, 4'd8,  MODE_CLICK, 16'h0000, 16'hFFFF, 0);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'hFFFF, 16'h0000, PREDICTED);
        add_row(OP_CONFIG, 4'd15, MODE_OFF,   16'hFFFF, 16'hFFFF, 0);
        add_row(OP_EVENT,  4'd0,  MODE_OFF,   16'h8000, 16'hFFFF, 0);
        add_row(OP_EVENT,  4'd7,  MODE_SEVEN, 16'h5555, 16'hFFFF, PREDICTED);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            deliver(dir_rows[k].item, 1'b0);
            dispatch_model(dir_rows[k].item);
            if (dir_rows[k].typed_n == PREDICTED)
            begin
                foreach (scan_res[ph])
                    pending_events.push_back(scan_res[ph]);
            end
            else if (dir_rows[k].typed_n > 0)
            begin
                pending_events.push_back(dir_rows[k].typed_res);
            end
        end

        // random phases: minimum, maximum, zero (wraps on the first step) and a small count
        phase_debounce = '{8'd1, 8'd255, 8'd0, 8'd3};
        foreach (phase_debounce[ph])
        begin
            set_debounce(phase_debounce[ph]);
            for (k = 0; k < PIN_COUNT + RAND_PER_PHASE; k++)
            begin
                it            = '0;
                it.pin_levels = 16'($urandom);
                // each phase opens by setting up every pin, then mixes configures and events
                if (k < PIN_COUNT || $urandom_range(0, 9) < 3)
                begin
                    it.operation   = OP_CONFIG;
                    it.pin         = (k < PIN_COUNT) ? 4'(k) : 4'($urandom_range(0, 15));
                    it.mode        = ($urandom_range(0, 2) == 0) ? MODE_CLICK
                                                                 : 3'($urandom_range(0, 7));
                    it.status_mask = 16'($urandom);
                end
                else
                begin
                    it.operation   = OP_EVENT;
                    it.pin         = 4'($urandom);
                    it.mode        = 3'($urandom);
                    it.status_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                end
                deliver(it, (k == PIN_COUNT + RAND_PER_PHASE / 2)
                            || ($urandom_range(0, 15) == 0));
                dispatch_model(it);
                foreach (scan_res[wait_cycles])
                    pending_events.push_back(scan_res[wait_cycles]);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (pending_events.size() != 0 && wait_cycles < END_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SCAN_DRAIN) @(posedge clk);
        if (pending_events.size() != 0)
            note_failure($sformatf("%0d events never arrived", pending_events.size()));

        if (mismatch_count == 0)
            $display("PASS gpio_irq_dispatch_click_debounce");
        else
            $display("FAIL gpio_irq_dispatch_click_debounce");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("FAIL gpio_irq_dispatch_click_debounce");
        $finish;
    end

endmodule
